// ===== design/view_frustum_sphere_cull_unit_defines.svh =====
// Assertion macros for the frustum cull unit
`ifndef VIEW_FRUSTUM_SPHERE_CULL_UNIT_DEFINES_SVH
`define VIEW_FRUSTUM_SPHERE_CULL_UNIT_DEFINES_SVH
`ifndef SYNTH
`define VFSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define VFSC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define VFSC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define VFSC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/vfsc_pkg.sv =====
package vfsc_pkg;
    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_REBUILD = 2'd1;
    localparam logic [1:0] REQ_TEST    = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROD_RD,
        ST_PROD_MAC,
        ST_PROD_WB,
        ST_PL_RD,
        ST_PL_COMB,
        ST_PL_SQ,
        ST_PL_SQRT,
        ST_PL_DIV,
        ST_PL_WB,
        ST_TS_RD,
        ST_TS_MAC,
        ST_TS_CMP,
        ST_OUT
    } t_state;

    // Divider / square-root request and reply
    typedef struct packed {
        logic        start;
        logic        is_sqrt;
        logic [63:0] num;
        logic [63:0] den;
    } t_iter_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] result;
    } t_iter_rsp;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > 68'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
        else if (v < -68'sh0_8000_0000) r = -32'sh8000_0000;
        else r = v[31:0];
        return r;
    endfunction
endpackage

// ===== design/vfsc_iter_unit.sv =====
// Shared bit-serial unit: restoring divide or integer square root, one bit a cycle
module vfsc_iter_unit
    import vfsc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_iter_req i_req,
    output t_iter_rsp o_rsp
);
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic        r_sqrt;
    logic [6:0]  r_cnt, n_cnt;
    logic [63:0] r_num, n_num;
    logic [63:0] r_den;
    logic [64:0] r_rem, n_rem;
    logic [63:0] r_res, n_res;

    logic [64:0] w_trial;
    logic [64:0] w_shrem;

    // Step one bit: divide shifts one numerator bit in, root two
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_rem  = r_rem;
        n_res  = r_res;
        w_shrem = '0;
        w_trial = '0;
        if (r_busy) begin
            if (r_sqrt) begin
                w_shrem = {r_rem[62:0], r_num[63:62]};
                w_trial = {r_res[62:0], 2'b01};
                n_num   = {r_num[61:0], 2'b00};
            end else begin
                w_shrem = {r_rem[63:0], r_num[63]};
                w_trial = {1'b0, r_den};
                n_num   = {r_num[62:0], 1'b0};
            end
            if (w_shrem >= w_trial) begin
                n_rem = w_shrem - w_trial;
                n_res = {r_res[62:0], 1'b1};
            end else begin
                n_rem = w_shrem;
                n_res = {r_res[62:0], 1'b0};
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Hold control under reset, load operands on start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start && !r_busy) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= i_req.is_sqrt ? 7'd32 : 7'd64;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_sqrt <= i_req.is_sqrt;
            r_num  <= i_req.num;
            r_den  <= i_req.den;
            r_rem  <= '0;
            r_res  <= '0;
        end else begin
            r_num <= n_num;
            r_rem <= n_rem;
            r_res <= n_res;
        end
    end

    assign o_rsp.busy   = r_busy;
    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_res;
endmodule

// ===== design/view_frustum_sphere_cull_unit.sv =====
// Load writes one matrix element. Sphere test: four read/MAC pairs and a compare per plane
// over the plane memory. Rebuild: matrix product, then per plane a 32-step square root
// and four 64-step divides in the shared bit-serial unit, both skipped for a zero normal.
// One request at a time, next accepted after the result transfers.
// Synchronous active-low reset clears control and the plane valid bits (planes read as zero).
`include "view_frustum_sphere_cull_unit_defines.svh"
module view_frustum_sphere_cull_unit
    import vfsc_pkg::*;
#(
    parameter int PLANE_COUNT = 6,
    parameter int FRAC_BITS   = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_req_type,
    input  logic               i_matrix_select,
    input  logic [3:0]         i_element_index,
    input  logic signed [31:0] i_element_value,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    input  logic [30:0]        i_radius,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_inside_res,
    output logic               o_plane_error,
    output logic [1:0]         o_done_kind
);
    localparam int PE = PLANE_COUNT * 4;
    localparam int PAW = (PE > 1) ? $clog2(PE) : 1;
    localparam int PLW = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;

    // Memories: matrices (32 entries, mv then proj), product (16), planes
    logic signed [31:0] r_mat  [0:31];
    logic signed [31:0] r_prod [0:15];
    logic signed [31:0] r_pl   [0:PE-1];
    logic [PLANE_COUNT-1:0] r_pl_vld;

    t_state r_st, n_st;
    logic [1:0]  r_kind;
    logic signed [31:0] r_px, r_py, r_pz;
    logic [30:0] r_rad;
    logic        r_inside, r_err;
    logic [3:0]  r_ei;      // product element index
    logic [1:0]  r_k;       // MAC term / component index
    logic [PLW-1:0] r_pk;   // plane index
    logic signed [67:0] r_acc;
    logic signed [31:0] r_ma, r_mb;   // registered memory reads
    logic signed [31:0] r_pc [0:3];   // plane components
    logic [63:0] r_sumsq;
    logic [63:0] r_len;
    logic [1:0]  r_mode;              // 0 sqrt, 1 divide in flight
    logic        r_iter_go;
    logic [1:0]  r_col_j;             // component read in PL_RD

    t_iter_req w_ireq;
    t_iter_rsp w_irsp;

    vfsc_iter_unit u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_ireq),
        .o_rsp   (w_irsp)
    );

    logic signed [63:0] w_mul;
    logic signed [63:0] w_fl;
    logic [1:0] w_col;
    logic [31:0] w_mag_c;
    logic w_neg;
    logic [63:0] w_q;
    logic signed [31:0] w_qs;
    logic w_pl_zero;

    assign o_ready   = (r_st == ST_IDLE);
    assign w_mul     = r_ma * r_mb;
    assign w_fl      = w_mul >>> FRAC_BITS;
    assign w_col     = 2'(r_pk >> 1);
    assign w_pl_zero = (r_pc[0] == 0 && r_pc[1] == 0 && r_pc[2] == 0);

    // Next-state logic
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_req_type == REQ_LOAD) n_st = ST_OUT;
                    else if (i_req_type == REQ_REBUILD) n_st = ST_PROD_RD;
                    else if (i_req_type == REQ_TEST) n_st = ST_TS_RD;
                end
            end
            ST_PROD_RD:  n_st = ST_PROD_MAC;
            ST_PROD_MAC: n_st = (r_k == 2'd3) ? ST_PROD_WB : ST_PROD_RD;
            ST_PROD_WB:  n_st = (r_ei == 4'd15) ? ST_PL_RD : ST_PROD_RD;
            ST_PL_RD:    n_st = ST_PL_COMB;
            ST_PL_COMB:  n_st = (r_col_j == 2'd3) ? ST_PL_SQ : ST_PL_RD;
            ST_PL_SQ:    n_st = (r_k == 2'd2) ? ST_PL_SQRT : ST_PL_SQ;
            ST_PL_SQRT: begin
                if (w_pl_zero) n_st = ST_PL_WB;
                else if (w_irsp.done) n_st = ST_PL_DIV;
            end
            ST_PL_DIV:   if (w_irsp.done && r_k == 2'd3) n_st = ST_PL_WB;
            ST_PL_WB: begin
                if (32'(r_pk) == PLANE_COUNT - 1) n_st = ST_OUT;
                else n_st = ST_PL_RD;
            end
            ST_TS_RD:    n_st = ST_TS_MAC;
            ST_TS_MAC:   n_st = (r_k == 2'd3) ? ST_TS_CMP : ST_TS_RD;
            ST_TS_CMP: begin
                if (32'(r_pk) == PLANE_COUNT - 1) n_st = ST_OUT;
                else n_st = ST_TS_RD;
            end
            ST_OUT:      if (i_ready) n_st = ST_IDLE;
            default:     n_st = ST_IDLE;
        endcase
    end

    // Iterative unit requests
    always_comb begin
        w_ireq.start   = r_iter_go;
        w_ireq.is_sqrt = (r_mode == 2'd0);
        w_ireq.num     = (r_mode == 2'd0) ? r_sumsq
                       : 64'(w_mag_c) << FRAC_BITS;
        w_ireq.den     = r_len;
    end

    assign w_neg   = r_pc[r_k][31];
    assign w_mag_c = w_neg ? 32'(-r_pc[r_k]) : r_pc[r_k];
    assign w_q     = w_irsp.result;
    always_comb begin
        if (w_neg) w_qs = (w_q > 64'h8000_0000) ? 32'sh8000_0000 : -w_q[31:0];
        else       w_qs = (w_q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : w_q[31:0];
    end

    assign o_valid       = (r_st == ST_OUT);
    assign o_inside_res  = r_inside;
    assign o_plane_error = r_err;
    assign o_done_kind   = r_kind;

    // Control registers; skip the root for a zero normal
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= ST_IDLE;
            r_pl_vld  <= '0;
            r_iter_go <= 1'b0;
        end else begin
            r_st      <= n_st;
            r_iter_go <= (r_st == ST_PL_SQ && r_k == 2'd2 && !w_pl_zero)
                      || (r_st == ST_PL_SQRT && w_irsp.done)
                      || (r_st == ST_PL_DIV && w_irsp.done && r_k != 2'd3);
            if (r_st == ST_PL_WB) r_pl_vld[r_pk] <= 1'b1;
        end
    end

    // Datapath: read, accumulate, write back
    always_ff @(posedge i_clk) begin
        unique case (r_st)
            ST_IDLE: begin
                r_kind <= i_req_type;
                r_px <= i_point_x; r_py <= i_point_y; r_pz <= i_point_z;
                r_rad <= i_radius;
                r_inside <= i_valid && (i_req_type == REQ_TEST);
                r_err <= 1'b0;
                r_ei <= '0; r_k <= '0; r_pk <= '0; r_acc <= '0; r_col_j <= '0;
                if (i_valid && i_req_type == REQ_LOAD)
                    r_mat[{i_matrix_select, i_element_index}] <= i_element_value;
            end
            ST_PROD_RD: begin
                r_ma <= r_mat[{1'b0, r_ei[3:2], r_k}];
                r_mb <= r_mat[{1'b1, r_k, r_ei[1:0]}];
            end
            ST_PROD_MAC: begin
                r_acc <= r_acc + 68'(w_fl);
                r_k   <= r_k + 2'd1;
            end
            ST_PROD_WB: begin
                r_prod[r_ei] <= sat32(r_acc);
                r_acc <= '0;
                r_ei  <= r_ei + 4'd1;
            end
            ST_PL_RD: begin
                r_ma <= r_prod[{r_col_j, 2'd3}];
                r_mb <= r_prod[{r_col_j, w_col}];
            end
            ST_PL_COMB: begin
                r_pc[r_col_j] <= sat32(r_pk[0] ? 68'(r_ma) + 68'(r_mb)
                                               : 68'(r_ma) - 68'(r_mb));
                r_col_j <= r_col_j + 2'd1;
                r_k <= '0;
                r_sumsq <= '0;
            end
            ST_PL_SQ: begin
                r_sumsq <= r_sumsq + 64'(r_pc[r_k]) * 64'(r_pc[r_k]);
                r_k <= r_k + 2'd1;
                r_mode <= 2'd0;
            end
            ST_PL_SQRT: begin
                r_k <= '0;
                if (w_irsp.done) begin
                    r_len  <= (w_irsp.result == 0) ? 64'd1 : w_irsp.result;
                    r_mode <= 2'd1;
                end
            end
            ST_PL_DIV: begin
                if (w_irsp.done) begin
                    r_pc[r_k] <= w_qs;
                    r_k <= r_k + 2'd1;
                end
            end
            ST_PL_WB: begin
                if (w_pl_zero) begin
                    r_err <= 1'b1;
                    for (int j = 0; j < 4; j++) r_pl[PAW'(32'(r_pk) * 4 + j)] <= '0;
                end else begin
                    for (int j = 0; j < 4; j++) r_pl[PAW'(32'(r_pk) * 4 + j)] <= r_pc[j];
                end
                r_pk <= r_pk + PLW'(1);
                r_col_j <= '0;
            end
            ST_TS_RD: begin
                r_mb <= r_pl_vld[r_pk] ? r_pl[PAW'(32'(r_pk) * 4 + 32'(r_k))] : '0;
                r_ma <= (r_k == 2'd0) ? r_px : (r_k == 2'd1) ? r_py
                      : (r_k == 2'd2) ? r_pz : 32'sd1;
            end
            ST_TS_MAC: begin
                r_acc <= r_acc + ((r_k == 2'd3) ? 68'(r_mb) : 68'(w_fl));
                r_k   <= r_k + 2'd1;
            end
            ST_TS_CMP: begin
                if (r_acc <= -$signed({37'd0, r_rad})) r_inside <= 1'b0;
                r_acc <= '0;
                r_pk  <= r_pk + PLW'(1);
            end
            ST_OUT: ;
            default: ;
        endcase
    end

    `VFSC_ASSERT_IMP(a_out_kind, i_clk, i_rst_n, o_valid, o_done_kind != 2'd3)
    `VFSC_ASSERT_IMP(a_err_rebuild, i_clk, i_rst_n, o_valid && o_plane_error, o_done_kind == REQ_REBUILD)
    `VFSC_ASSERT_IMP(a_in_test, i_clk, i_rst_n, o_valid && o_inside_res, o_done_kind == REQ_TEST)
    `VFSC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
endmodule

// ===== test/view_frustum_sphere_cull_unit_checker.sv =====
`timescale 1ns / 1ps
module view_frustum_sphere_cull_unit_checker
    import vfsc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_ready_in,
    input  logic [1:0]         i_req_type,
    input  logic               i_matrix_select,
    input  logic [3:0]         i_element_index,
    input  logic signed [31:0] i_element_value,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    input  logic [30:0]        i_radius,
    input  logic               i_out_valid,
    input  logic               i_ready,
    input  logic               i_inside_res,
    input  logic               i_plane_error,
    input  logic [1:0]         i_done_kind,
    output int                 o_fail_count,
    output int                 o_pending
);
    localparam int FRAC = 16;
    localparam int PLANES = 6;

    typedef struct packed {
        logic       vis;
        logic       perr;
        logic [1:0] kind;
    } cull_answer_t;

    logic signed [31:0] mv_mat[16];
    logic signed [31:0] pj_mat[16];
    logic signed [31:0] plane_mem[PLANES*4];
    cull_answer_t       answers_due[$];

    // Q16.16 product, floored
    function automatic logic signed [63:0] fix_mul(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [63:0] ea;
        logic signed [63:0] eb;
        logic signed [63:0] p;
        ea = a;
        eb = b;
        p  = ea * eb;
        return p >>> FRAC;
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bit_v;
        rem = n;
        res = '0;
        for (int i = 31; i >= 0; i--) begin
            bit_v = 64'd1 << (2 * i);
            if (rem >= res + bit_v) begin
                rem = rem - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
        end
        return res;
    endfunction

    function automatic logic signed [31:0] unit_scale(input logic signed [31:0] c,
                                                      input logic [63:0] len);
        logic [63:0] mag;
        logic [63:0] q;
        logic signed [63:0] ec;
        ec  = c;
        mag = (c < 0) ? 64'(-ec) : 64'(ec);
        q   = (mag << FRAC) / len;
        if (c < 0) return (q > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-$signed(q));
        return (q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q[31:0];
    endfunction

    // Multiply the matrices, extract and normalise the planes
    function automatic logic rebuild_frustum();
        logic signed [31:0] prod[16];
        logic signed [31:0] pc[4];
        logic signed [63:0] acc;
        logic signed [63:0] ea;
        logic signed [63:0] eb;
        logic signed [63:0] sq;
        logic [63:0]        sumsq;
        logic [63:0]        len;
        logic               err;
        int                 col;
        err = 1'b0;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                acc = 0;
                for (int k = 0; k < 4; k++)
                    acc += fix_mul(mv_mat[r*4+k], pj_mat[k*4+c]);
                prod[r*4+c] = clamp32(acc);
            end
        end
        for (int k = 0; k < PLANES; k++) begin
            col = (k >> 1) & 3;
            for (int j = 0; j < 4; j++) begin
                ea = prod[j*4+3];
                eb = prod[j*4+col];
                pc[j] = clamp32((k & 1) ? ea + eb : ea - eb);
            end
            sumsq = '0;
            for (int j = 0; j < 3; j++) begin
                ea = pc[j];
                sq = ea * ea;
                sumsq += 64'(sq);
            end
            if (pc[0] == 0 && pc[1] == 0 && pc[2] == 0) begin
                for (int j = 0; j < 4; j++) plane_mem[k*4+j] = '0;
                err = 1'b1;
            end else begin
                len = int_sqrt(sumsq);
                if (len == 0) len = 1;
                for (int j = 0; j < 4; j++) plane_mem[k*4+j] = unit_scale(pc[j], len);
            end
        end
        return err;
    endfunction

    function automatic logic sphere_visible(input logic signed [31:0] x,
                                            input logic signed [31:0] y,
                                            input logic signed [31:0] z,
                                            input logic [30:0] rad);
        logic signed [63:0] plane_dist;
        logic signed [63:0] neg_rad;
        neg_rad = -$signed({33'b0, rad});
        for (int k = 0; k < PLANES; k++) begin
            plane_dist = fix_mul(x, plane_mem[k*4]) + fix_mul(y, plane_mem[k*4+1])
                       + fix_mul(z, plane_mem[k*4+2]) + 64'(plane_mem[k*4+3]);
            if (plane_dist <= neg_rad) return 1'b0;
        end
        return 1'b1;
    endfunction

    initial begin
        o_fail_count = 0;
        for (int i = 0; i < PLANES*4; i++) plane_mem[i] = '0;
        for (int i = 0; i < 16; i++) begin
            mv_mat[i] = '0;
            pj_mat[i] = '0;
        end
    end

    assign o_pending = answers_due.size();

    always @(posedge i_clk) begin
        cull_answer_t want;
        cull_answer_t got;
        if (i_rst_n) begin
            // Compare each result transfer with the oldest expectation
            if (i_out_valid && i_ready) begin
                got = '{vis: i_inside_res, perr: i_plane_error, kind: i_done_kind};
                if (answers_due.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: unexpected result %p", $time, got);
                end else begin
                    want = answers_due.pop_front();
                    if (want !== got) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("%0t: mismatch expected %p actual %p", $time, want, got);
                    end
                end
            end
            // Advance the model on each request transfer
            if (i_valid && i_ready_in) begin
                want = '0;
                want.kind = i_req_type;
                case (i_req_type)
                    REQ_LOAD: begin
                        if (i_matrix_select) pj_mat[i_element_index] = i_element_value;
                        else mv_mat[i_element_index] = i_element_value;
                        answers_due.push_back(want);
                    end
                    REQ_REBUILD: begin
                        want.perr = rebuild_frustum();
                        answers_due.push_back(want);
                    end
                    REQ_TEST: begin
                        want.vis = sphere_visible(i_point_x, i_point_y, i_point_z,
                                                  i_radius);
                        answers_due.push_back(want);
                    end
                    default: ;
                endcase
            end
        end
    end
endmodule

// ===== test/tb_view_frustum_sphere_cull_unit.sv =====
`timescale 1ns / 1ps
module tb_view_frustum_sphere_cull_unit;
    import vfsc_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int ITEM_TARGET = 1650;
    localparam int ONE = 32'h0001_0000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [1:0]         i_req_type = REQ_LOAD;
    logic               i_matrix_select = 1'b0;
    logic [3:0]         i_element_index = '0;
    logic signed [31:0] i_element_value = '0;
    logic signed [31:0] i_point_x = '0;
    logic signed [31:0] i_point_y = '0;
    logic signed [31:0] i_point_z = '0;
    logic [30:0]        i_radius = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic               o_inside_res;
    logic               o_plane_error;
    logic [1:0]         o_done_kind;

    int fail_count;
    int pending;
    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int items_sent = 0;

    always #5 i_clk = ~i_clk;

    view_frustum_sphere_cull_unit u_dut (.*);

    view_frustum_sphere_cull_unit_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_ready_in(o_ready),
        .i_req_type(i_req_type), .i_matrix_select(i_matrix_select),
        .i_element_index(i_element_index), .i_element_value(i_element_value),
        .i_point_x(i_point_x), .i_point_y(i_point_y), .i_point_z(i_point_z),
        .i_radius(i_radius), .i_out_valid(o_valid), .i_ready(i_ready),
        .i_inside_res(o_inside_res), .i_plane_error(o_plane_error),
        .i_done_kind(o_done_kind), .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver: random stalls, plus a long hold-off on request
    initial begin
        int hold_left;
        int holds_seen;
        hold_left = 0;
        holds_seen = 0;
        forever begin
            @(posedge i_clk);
            if (hold_requests != holds_seen) begin
                holds_seen = hold_requests;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_req(input logic [1:0] kind, input logic sel, input logic [3:0] idx,
                            input logic [31:0] val, input logic [31:0] x,
                            input logic [31:0] y, input logic [31:0] z,
                            input logic [30:0] rad);
        // Hold off for random idle cycles before offering
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_req_type      <= kind;
        i_matrix_select <= sel;
        i_element_index <= idx;
        i_element_value <= val;
        i_point_x       <= x;
        i_point_y       <= y;
        i_point_z       <= z;
        i_radius        <= rad;
        do @(posedge i_clk); while (!o_ready);
        if (kind != REQ_UNUSED) items_sent++;
    endtask

    task automatic load_elem(input logic sel, input logic [3:0] idx, input logic [31:0] val);
        send_req(REQ_LOAD, sel, idx, val, $urandom, $urandom, $urandom, 31'($urandom));
    endtask

    task automatic rebuild();
        send_req(REQ_REBUILD, 1'($urandom), 4'($urandom), $urandom, $urandom, $urandom,
                 $urandom, 31'($urandom));
    endtask

    task automatic test_sphere(input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z, input logic [30:0] rad);
        send_req(REQ_TEST, 1'($urandom), 4'($urandom), $urandom, x, y, z, rad);
    endtask

    function automatic logic [31:0] pick_coord();
        int r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(0, 16 * ONE) - 8 * ONE;
        if (r < 85) return $urandom;
        return r[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
    endfunction

    function automatic logic [30:0] pick_radius();
        int r;
        r = $urandom_range(99);
        if (r < 70) return 31'($urandom_range(0, 4 * ONE));
        if (r < 80) return '0;
        return 31'($urandom);
    endfunction

    function automatic logic [31:0] pick_elem(input int style);
        if (style == 1) return $urandom;
        if (style == 2 && $urandom_range(1)) return '0;
        return $urandom_range(0, 8 * ONE) - 4 * ONE;
    endfunction

    task automatic random_test();
        test_sphere(pick_coord(), pick_coord(), pick_coord(), pick_radius());
    endtask

    // Drop valid and wait until every expected result has transferred
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // One frame: load most matrix elements, usually rebuild, then test a batch of spheres
    task automatic run_frame(input int style);
        for (int e = 0; e < 32; e++) begin
            if ($urandom_range(99) < 15) random_test();
            if ($urandom_range(99) < 3)
                send_req(REQ_UNUSED, 1'($urandom), 4'($urandom), $urandom, $urandom,
                         $urandom, $urandom, 31'($urandom));
            if ($urandom_range(99) < 90) load_elem(e[4], e[3:0], pick_elem(style));
        end
        if ($urandom_range(99) < 90) rebuild();
        for (int t = $urandom_range(30, 50); t > 0; t--) begin
            if ($urandom_range(99) < 8)
                load_elem(1'($urandom), 4'($urandom), pick_elem(style));
            else random_test();
        end
    endtask

    initial begin
        int frame;
        int style;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero model-view: every plane collapses and the rebuild flags it
        for (int i = 0; i < 16; i++) load_elem(1'b0, i[3:0], 32'h0);
        for (int i = 0; i < 16; i++)
            load_elem(1'b1, i[3:0], (i == 0) ? 32'h7FFF_FFFF :
                                   (i == 15) ? 32'h8000_0000 : pick_elem(0));
        rebuild();
        test_sphere(32'h0, 32'h0, 32'h0, 31'h0);
        test_sphere(32'h0, 32'h0, 32'h0, 31'h1);
        // Identity model-view: planes come straight from the projection
        for (int i = 0; i < 4; i++) load_elem(1'b0, 4'(i * 5), ONE);
        rebuild();
        test_sphere(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
        test_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h0);
        test_sphere(32'h0, 32'h0, 32'h0, 31'h7FFF_FFFF);
        send_req(REQ_UNUSED, 1'b1, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 31'h7FFF_FFFF);

        // Random frames across the idling phases
        frame = 0;
        while (items_sent < ITEM_TARGET) begin
            case (frame % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin sender_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            style = ($urandom_range(99) < 70) ? 0 : $urandom_range(1, 2);
            if (frame == 3) begin
                // Long receiver hold-off while requests keep coming
                hold_requests++;
                for (int i = 0; i < 6; i++) random_test();
            end
            if (frame == 5) wait_drained();
            run_frame(style);
            frame++;
        end
        wait_drained();
        repeat (2000) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule
